### hw/rtl/sia_pkg.sv
// ============================================================================
// sia_pkg - shared definitions for the stable index argsort
// Port field widths, parameter defaults and the control word that the top
// level broadcasts to every sort cell.
// ============================================================================
`default_nettype none

package sia_pkg;

    // fixed widths of the request and result fields
    localparam int KEY_W     = 20;
    localparam int IDX_OUT_W = 6;

    // parameter defaults
    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_BITS_DEF  = 20;

    // per-cycle command to the cell chain
    typedef struct packed {
        logic ins;    // insert the broadcast key this cycle
        logic shift;  // drain: every cell takes its right neighbor
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/sia_req_if.sv
// ============================================================================
// sia_req_if - request channel of the argsort
// Valid/ready channel carrying one key and the end-of-set mark.
// ============================================================================
`default_nettype none

interface sia_req_if
    import sia_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;
    logic             last;

    modport source (output valid, output key, output last, input ready);
    modport sink   (input valid, input key, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/sia_res_if.sv
// ============================================================================
// sia_res_if - result channel of the argsort
// Valid/ready channel carrying one ranked arrival index per stored key.
// ============================================================================
`default_nettype none

interface sia_res_if
    import sia_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] item_index;
    logic                 run_end;
    logic                 dropped;

    modport source (output valid, output item_index, output run_end, output dropped,
                    input ready);
    modport sink   (input valid, input item_index, input run_end, input dropped,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/stable_index_argsort.sv
// ============================================================================
// stable_index_argsort - stable ascending argsort over a chain of cells
// Keys are inserted into a sorted chain as they arrive; the request marked
// last starts a drain that returns arrival indexes in ascending key order.
// ============================================================================
//
//  channel  | dir | payload                          | note
//  ---------+-----+----------------------------------+------------------------
//  i_req    | in  | key, last                        | one key per request
//  o_res    | out | item_index, run_end, dropped     | one per stored key
//
//  Loading: every cell compares against the broadcast key in parallel and
//  the chain opens a slot in the same cycle.
//  The drain returns the stored keys in order, held by o_res stalls; cell 0 is
//  the output register and the chain shifts left on each accepted result.
//  i_req.ready is low for the whole drain; keys beyond MAX_ITEMS are dropped.
//  Synchronous active-low reset empties the chain; no clearing pass needed.
// ============================================================================
`default_nettype none

module stable_index_argsort
    import sia_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sia_req_if.sink    i_req,
    sia_res_if.source  o_res
);

    localparam int FILL_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);

    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_drain, n_drain;
    logic                r_ovf, n_ovf;

    logic                w_req_fire;
    logic                w_res_fire;
    logic                w_has_room;
    t_cell_ctl           w_ctl;
    logic [KEY_BITS-1:0] w_new_key;
    logic [IDX_W-1:0]    w_new_idx;

    logic                w_gt  [MAX_ITEMS];
    logic [KEY_BITS-1:0] w_key [MAX_ITEMS];
    logic [IDX_W-1:0]    w_idx [MAX_ITEMS];

    // handshakes
    assign i_req.ready = !r_drain;
    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_res_fire  = o_res.valid && o_res.ready;
    assign w_has_room  = r_fill < FILL_W'(MAX_ITEMS);

    // broadcast to the chain
    assign w_ctl.ins   = w_req_fire && w_has_room;
    assign w_ctl.shift = w_res_fire;
    assign w_new_key   = KEY_BITS'(i_req.key);
    assign w_new_idx   = r_fill[IDX_W-1:0];

    // cell chain
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                w_lgt;
        logic [KEY_BITS-1:0] w_lkey, w_rkey;
        logic [IDX_W-1:0]    w_lidx, w_ridx;

        if (g == 0) begin : g_head
            assign w_lgt  = 1'b0;
            assign w_lkey = w_new_key;
            assign w_lidx = w_new_idx;
        end else begin : g_mid
            assign w_lgt  = w_gt[g-1];
            assign w_lkey = w_key[g-1];
            assign w_lidx = w_idx[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_rkey = w_key[g];
            assign w_ridx = w_idx[g];
        end else begin : g_body
            assign w_rkey = w_key[g+1];
            assign w_ridx = w_idx[g+1];
        end

        sia_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX_W    (IDX_W),
            .FILL_W   (FILL_W),
            .POS      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_fill      (r_fill),
            .i_new_key   (w_new_key),
            .i_new_idx   (w_new_idx),
            .i_left_gt   (w_lgt),
            .i_left_key  (w_lkey),
            .i_left_idx  (w_lidx),
            .i_right_key (w_rkey),
            .i_right_idx (w_ridx),
            .o_gt        (w_gt[g]),
            .o_key       (w_key[g]),
            .o_idx       (w_idx[g])
        );
    end

    // result comes straight from the head cell
    assign o_res.valid      = r_drain;
    assign o_res.item_index = IDX_OUT_W'(w_idx[0]);
    assign o_res.run_end    = r_fill == FILL_W'(1);
    assign o_res.dropped    = r_ovf;

    // fill count, overflow flag and drain mode
    always_comb begin
        n_fill  = r_fill;
        n_drain = r_drain;
        n_ovf   = r_ovf;
        if (w_req_fire) begin
            if (w_has_room) begin
                n_fill = r_fill + FILL_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (i_req.last) begin
                n_drain = 1'b1;
            end
        end
        if (w_res_fire) begin
            n_fill = r_fill - FILL_W'(1);
            if (r_fill == FILL_W'(1)) begin
                n_drain = 1'b0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sia_cell.sv
// ============================================================================
// sia_cell - one slot of the insertion chain
// Holds one key and its arrival index. On insert it either keeps its entry,
// takes its left neighbor's entry, or takes the new key; on drain it takes
// its right neighbor's entry.
// ============================================================================
`default_nettype none

module sia_cell
    import sia_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int IDX_W    = 6,
    parameter int FILL_W   = 7,
    parameter int POS      = 0
) (
    input  wire logic                i_clk,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [FILL_W-1:0]   i_fill,
    input  wire logic [KEY_BITS-1:0] i_new_key,
    input  wire logic [IDX_W-1:0]    i_new_idx,
    input  wire logic                i_left_gt,
    input  wire logic [KEY_BITS-1:0] i_left_key,
    input  wire logic [IDX_W-1:0]    i_left_idx,
    input  wire logic [KEY_BITS-1:0] i_right_key,
    input  wire logic [IDX_W-1:0]    i_right_idx,
    output logic                     o_gt,
    output logic [KEY_BITS-1:0]      o_key,
    output logic [IDX_W-1:0]         o_idx
);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                w_occupied;
    logic                w_at_end;

    // strict compare keeps equal keys in arrival order
    assign w_occupied = i_fill > FILL_W'(POS);
    assign w_at_end   = i_fill == FILL_W'(POS);
    assign o_gt       = w_occupied && (r_key > i_new_key);

    // next entry: make room for the new key or shift toward the output
    always_comb begin
        n_key = r_key;
        n_idx = r_idx;
        if (i_ctl.shift) begin
            n_key = i_right_key;
            n_idx = i_right_idx;
        end else if (i_ctl.ins && (o_gt || w_at_end)) begin
            if (i_left_gt) begin
                n_key = i_left_key;
                n_idx = i_left_idx;
            end else begin
                n_key = i_new_key;
                n_idx = i_new_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_idx <= n_idx;
    end

    assign o_key = r_key;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

### hw/rtl/sia_checker.sv
// ============================================================================
// sia_checker - port-level checks for the argsort
// Watches both channels of the top level and is bound to it below.
// ============================================================================
`default_nettype none

module sia_checker
    import sia_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_req_valid,
    input wire logic                 i_req_ready,
    input wire logic                 i_req_last,
    input wire logic                 i_res_valid,
    input wire logic                 i_res_ready,
    input wire logic [IDX_OUT_W-1:0] i_res_item_index,
    input wire logic                 i_res_run_end
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its index
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_item_index))
        else $error("result index changed while stalled");

    // no request is taken during a drain
    a_no_load_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_req_ready)
        else $error("request ready during drain");

    // the request that closes a set starts the drain at once
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_last |=> i_res_valid)
        else $error("no drain after last request");

    // the run ends with the flagged result
    a_run_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && i_res_run_end |=> !i_res_valid)
        else $error("results continue after run end");

endmodule

bind stable_index_argsort sia_checker u_sia_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_last       (i_req.last),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_item_index (o_res.item_index),
    .i_res_run_end    (o_res.run_end)
);

`default_nettype wire
